### hdl/ialu_pkg.sv
// Package for the 64-bit integer ALU.
// Holds the transaction types, opcodes, status codes and sizing constants.
// No dependencies.
`default_nettype none
package ialu_pkg;
   localparam int DATA_W     = 64;
   localparam int SHAMT_W    = $clog2(DATA_W);
   localparam int HALF_W     = DATA_W / 2;
   localparam int MQ_DEPTH   = 4;
   localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
   localparam int DIV_STAGES = DATA_W;

   typedef enum logic [3:0] {
      OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
      OP_MOD = 4'd5, OP_SHL = 4'd6, OP_SHR = 4'd7, OP_AND = 4'd8,
      OP_OR  = 4'd9, OP_XOR = 4'd10, OP_ROL = 4'd11, OP_ROR = 4'd12
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_BAD_OP = 2'd2, ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0, KIND_MUL = 2'd1, KIND_DIV = 2'd2
   } kind_type;

   typedef struct packed {
      logic [3:0]        action;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic              is_mod;
      logic              neg_q;
      logic              neg_r;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] opa;
      logic [DATA_W-1:0] opb;
   } work_type;
endpackage
`default_nettype wire

### hdl/ialu_front.sv
// Front end of the integer ALU: decodes and classifies each transaction.
// Computes simple results, error status and divider magnitudes. Uses ialu_pkg.
`default_nettype none
module ialu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire ialu_pkg::req_type req_data,
   output logic                   out_valid,
   input  wire logic              out_full,
   output ialu_pkg::work_type     out_work
);
   localparam logic [ialu_pkg::DATA_W-1:0] MinVal = {1'b1, {(ialu_pkg::DATA_W-1){1'b0}}};

   logic                  valid_ff, valid_in;
   ialu_pkg::work_type    work_ff, work_in;
   logic [ialu_pkg::DATA_W-1:0]   a, b;
   logic [2*ialu_pkg::DATA_W-1:0] rol_w, ror_w;
   logic [ialu_pkg::SHAMT_W-1:0]  s;
   logic                  long_sh, take;

   assign full      = valid_ff && out_full;
   assign take      = push && !full;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      a       = req_data.operand_a;
      b       = req_data.operand_b;
      s       = b[ialu_pkg::SHAMT_W-1:0];
      long_sh = (b >= ialu_pkg::DATA_W);
      rol_w   = {a, a} << s;
      ror_w   = {a, a} >> s;
      work_in = '0;
      work_in.kind   = ialu_pkg::KIND_SIMPLE;
      work_in.status = ialu_pkg::ST_OK;
      work_in.opa    = a;
      work_in.opb    = b;
      case (req_data.action)
         ialu_pkg::OP_ADD: work_in.res = a + b;
         ialu_pkg::OP_SUB: work_in.res = a - b;
         ialu_pkg::OP_MUL: work_in.kind = ialu_pkg::KIND_MUL;
         ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
            work_in.kind   = ialu_pkg::KIND_DIV;
            work_in.is_mod = (req_data.action == ialu_pkg::OP_MOD);
            work_in.neg_r  = a[ialu_pkg::DATA_W-1];
            work_in.neg_q  = a[ialu_pkg::DATA_W-1] ^ b[ialu_pkg::DATA_W-1];
            work_in.opa    = a[ialu_pkg::DATA_W-1] ? -a : a;
            work_in.opb    = b[ialu_pkg::DATA_W-1] ? -b : b;
            if (b == '0) begin
               work_in.status = ialu_pkg::ST_DIV_ZERO;
            end else if (a == MinVal && b == '1) begin
               work_in.status = ialu_pkg::ST_OVERFLOW;
            end
         end
         ialu_pkg::OP_SHL: work_in.res = long_sh ? '0 : (a << s);
         ialu_pkg::OP_SHR: work_in.res = long_sh ? '0 : (a >> s);
         ialu_pkg::OP_AND: work_in.res = a & b;
         ialu_pkg::OP_OR:  work_in.res = a | b;
         ialu_pkg::OP_XOR: work_in.res = a ^ b;
         ialu_pkg::OP_ROL: work_in.res = rol_w[2*ialu_pkg::DATA_W-1:ialu_pkg::DATA_W];
         ialu_pkg::OP_ROR: work_in.res = ror_w[ialu_pkg::DATA_W-1:0];
         default:          work_in.status = ialu_pkg::ST_BAD_OP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (valid_ff && !out_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         work_ff <= work_in;
      end
   end
endmodule
`default_nettype wire

### hdl/ialu_queue.sv
// Short queue between the front and back ends of the integer ALU.
// Holds decoded work transactions. Uses ialu_pkg.
`default_nettype none
module ialu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire ialu_pkg::work_type wr_data,
   output logic                    is_full,
   output logic                    is_empty,
   input  wire logic               rd_en,
   output ialu_pkg::work_type      rd_data
);
   ialu_pkg::work_type            mem [ialu_pkg::MQ_DEPTH];
   logic [ialu_pkg::MQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ialu_pkg::MQ_PTR_W:0]   count_ff, count_in;
   logic                          do_wr, do_rd;

   assign is_full  = (count_ff == ialu_pkg::MQ_DEPTH[ialu_pkg::MQ_PTR_W:0]);
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;
   assign rd_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{ialu_pkg::MQ_PTR_W{1'b0}}, do_wr}
                           - {{ialu_pkg::MQ_PTR_W{1'b0}}, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

### hdl/ialu_back.sv
// Back end of the integer ALU: pipelined multiplier, one-bit-per-stage divider
// and a two-entry result queue. Uses ialu_pkg.
`default_nettype none
module ialu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire ialu_pkg::work_type in_work,
   output logic                    in_take,
   output logic                    empty,
   input  wire logic               pop,
   output ialu_pkg::rsp_type       rsp_data
);
   localparam int DW = ialu_pkg::DATA_W;
   localparam int HW = ialu_pkg::HALF_W;
   localparam int NS = ialu_pkg::DIV_STAGES;

   ialu_pkg::work_type stage_ff [NS];
   ialu_pkg::work_type stage_in [NS];
   logic [NS-1:0]      valid_ff;
   logic [DW-1:0]      rem_ff [NS];
   logic [DW-1:0]      rem_in [NS];
   logic [DW-1:0]      pp_ll_ff, pp_lh_ff, pp_hl_ff;
   logic               en;

   ialu_pkg::rsp_type  oq_ff [2];
   logic               oq_wr_ff, oq_rd_ff;
   logic [1:0]         oq_cnt_ff, oq_cnt_in;
   logic               oq_push, oq_pop;
   ialu_pkg::rsp_type  fin;
   logic [DW-1:0]      q_fin, r_fin;

   assign oq_pop   = pop && (oq_cnt_ff != 2'd0);
   assign en       = (oq_cnt_ff != 2'd2) || oq_pop;
   assign in_take  = en && in_valid;
   assign oq_push  = en && valid_ff[NS-1];
   assign empty    = (oq_cnt_ff == 2'd0);
   assign rsp_data = oq_ff[oq_rd_ff];

   always_comb begin
      logic [DW-1:0] sh;
      ialu_pkg::work_type w;
      logic [DW-1:0] r;
      for (int k = 0; k < NS; k++) begin
         w = (k == 0) ? in_work : stage_ff[(k == 0) ? 0 : k-1];
         r = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         if (k == 1 && w.kind == ialu_pkg::KIND_MUL) begin
            w.res = pp_ll_ff + {pp_lh_ff[HW-1:0] + pp_hl_ff[HW-1:0], {HW{1'b0}}};
         end
         sh = {r[DW-2:0], w.opa[DW-1]};
         w.opa = {w.opa[DW-2:0], 1'b0};
         if (sh >= w.opb) begin
            sh = sh - w.opb;
            w.opa[0] = 1'b1;
         end
         stage_in[k] = w;
         rem_in[k]   = sh;
      end
   end

   always_comb begin
      q_fin = stage_ff[NS-1].neg_q ? -stage_ff[NS-1].opa : stage_ff[NS-1].opa;
      r_fin = stage_ff[NS-1].neg_r ? -rem_ff[NS-1] : rem_ff[NS-1];
      fin.status = stage_ff[NS-1].status;
      if (stage_ff[NS-1].status != ialu_pkg::ST_OK) begin
         fin.result = '0;
      end else if (stage_ff[NS-1].kind == ialu_pkg::KIND_DIV) begin
         fin.result = stage_ff[NS-1].is_mod ? r_fin : q_fin;
      end else begin
         fin.result = stage_ff[NS-1].res;
      end
      oq_cnt_in = oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[NS-2:0], in_valid};
         end
         if (oq_push) begin
            oq_wr_ff <= !oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= !oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_in;
      end
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            stage_ff[k] <= stage_in[k];
            rem_ff[k]   <= rem_in[k];
         end
         pp_ll_ff <= in_work.opa[HW-1:0] * in_work.opb[HW-1:0];
         pp_lh_ff <= in_work.opa[HW-1:0] * in_work.opb[DW-1:HW];
         pp_hl_ff <= in_work.opa[DW-1:HW] * in_work.opb[HW-1:0];
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= fin;
      end
   end
endmodule
`default_nettype wire

### hdl/integer_alu_64.sv
// Top level of the 64-bit integer ALU: front end, work queue and back end.
// Depends on ialu_pkg, ialu_front, ialu_queue and ialu_back.
// A transaction goes from acceptance to the result showing through the front
// register, the work queue and the 64-stage divider pipeline that every transaction passes through.
// Throughput is one transaction per cycle while results are taken.
// Synchronous reset empties all queues and pipeline stages.
`default_nettype none
module integer_alu_64 (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire ialu_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output ialu_pkg::rsp_type      rsp_data
);
   logic               f_valid, mq_full, mq_empty, b_take;
   ialu_pkg::work_type f_work, mq_work;

   ialu_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .out_valid(f_valid), .out_full(mq_full), .out_work(f_work)
   );

   ialu_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(f_valid), .wr_data(f_work),
      .is_full(mq_full), .is_empty(mq_empty), .rd_en(b_take), .rd_data(mq_work)
   );

   ialu_back u_back (
      .clock(clock), .reset(reset), .in_valid(!mq_empty), .in_work(mq_work),
      .in_take(b_take), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

### hdl/ialu_checker.sv
// Port-level checks for the integer ALU and the bind that attaches them.
// Depends on ialu_pkg and integer_alu_64.
`default_nettype none
module ialu_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire ialu_pkg::rsp_type rsp_data
);
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != ialu_pkg::ST_OK) |-> (rsp_data.result == '0))
      else $error("Error transaction carries a non-zero result.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("Waiting result transaction changed or vanished.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("Block not empty and ready after reset.");
endmodule

bind integer_alu_64 ialu_checker u_ialu_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_data(rsp_data)
);
`default_nettype wire
